>>> src/i2cm_pkg.sv
// Package for the I2C register access master: word types, phase codes and constants.
// Used by i2c_master_register_access_top and its checker; depends on nothing else.
`timescale 1ns / 1ps
package i2cm_pkg;

   localparam int unsigned PhaseTicksWidth = 16;
   localparam logic [PhaseTicksWidth-1:0] PhaseTicksReset = 16'd5;

   // Request codes
   localparam logic [1:0] REQ_TICK  = 2'd0;
   localparam logic [1:0] REQ_BEGIN = 2'd1;
   localparam logic [1:0] REQ_WDATA = 2'd2;

   // Completion status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_ADDR_NACK = 2'd1;
   localparam logic [1:0] STATUS_DATA_NACK = 2'd2;

   // Byte stage codes
   localparam logic [1:0] STG_ADDR_W = 2'd0;
   localparam logic [1:0] STG_REG    = 2'd1;
   localparam logic [1:0] STG_ADDR_R = 2'd2;
   localparam logic [1:0] STG_DATA   = 2'd3;

   // Waveform phases, one-hot
   typedef enum logic [16:0] {
      PH_IDLE = 17'h00001,
      PH_ST1  = 17'h00002,
      PH_ST2  = 17'h00004,
      PH_ST3  = 17'h00008,
      PH_TX1  = 17'h00010,
      PH_TX2  = 17'h00020,
      PH_TX3  = 17'h00040,
      PH_AK1  = 17'h00080,
      PH_AK2  = 17'h00100,
      PH_AK3  = 17'h00200,
      PH_RX1  = 17'h00400,
      PH_RX2  = 17'h00800,
      PH_MA1  = 17'h01000,
      PH_MA2  = 17'h02000,
      PH_MA3  = 17'h04000,
      PH_WAIT = 17'h08000,
      PH_STOP = 17'h10000
   } phase_type;

   typedef struct packed {
      logic [1:0] req_type;
      logic       is_read;
      logic [6:0] dev_addr;
      logic [7:0] reg_addr;
      logic [7:0] byte_count;
      logic [7:0] write_byte;
      logic       sda_sample;
   } req_word_type;

   typedef struct packed {
      logic       scl_drive;
      logic       sda_drive;
      logic [7:0] read_byte;
      logic       read_valid;
      logic       need_write_byte;
      logic       busy_res;
      logic       done_res;
      logic [1:0] status;
   } rsp_word_type;

endpackage

>>> src/i2c_master_register_access_top.sv
// Top level of the I2C register access master: phase sequencer and result word register.
// Depends on i2cm_pkg.
//
//   channel | direction | word          | handshake
//   req_    | in        | req_word_type | req_valid / req_ready
//   rsp_    | out       | rsp_word_type | rsp_valid / rsp_ready
//   csr_    | in        | phase_ticks   | csr_valid / csr_ready
//
// Each request word is handled at the edge that accepts it: the state and the result word are
// updated there, so one word is taken per cycle while the result register is
// empty or being drained. The result register is the only buffer; a stalled rsp_ holds
// req_ready low. Synchronous reset returns the bus to released lines and phase idle.
`timescale 1ns / 1ps
module i2c_master_register_access_top #(
   parameter int unsigned PHASE_TICKS_WIDTH = i2cm_pkg::PhaseTicksWidth
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  i2cm_pkg::req_word_type        req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output i2cm_pkg::rsp_word_type        rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [PHASE_TICKS_WIDTH-1:0]  csr_data
);

   i2cm_pkg::phase_type phase_ff, phase_in;
   logic [PHASE_TICKS_WIDTH-1:0] ticks_ff, ticks_in;
   logic [PHASE_TICKS_WIDTH-1:0] count_ff, count_in;
   logic [2:0] bit_ff, bit_in;
   logic [7:0] shift_ff, shift_in;
   logic [7:0] left_ff, left_in;
   logic [6:0] addr_ff, addr_in;
   logic [7:0] reg_ff, reg_in;
   logic       rd_ff, rd_in;
   logic       scl_ff, scl_in;
   logic       sda_ff, sda_in;
   logic [1:0] stage_ff, stage_in;
   logic       nack_ff, nack_in;
   logic [1:0] err_ff, err_in;
   logic       rsp_valid_ff;
   i2cm_pkg::rsp_word_type rsp_ff, rsp_in;

   logic accept;
   logic ev_valid, ev_done;
   logic [7:0] ev_byte;
   logic [PHASE_TICKS_WIDTH-1:0] limit, cnt_inc;
   i2cm_pkg::phase_type go_ph;
   logic do_go;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign ticks_in = (csr_valid) ? csr_data : ticks_ff;
   assign limit    = (ticks_ff == '0) ? PHASE_TICKS_WIDTH'(1) : ticks_ff;
   assign cnt_inc  = count_ff + PHASE_TICKS_WIDTH'(1);

   // Next-state logic: decide the phase to enter, then apply its line levels.
   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      bit_in   = bit_ff;
      shift_in = shift_ff;
      left_in  = left_ff;
      addr_in  = addr_ff;
      reg_in   = reg_ff;
      rd_in    = rd_ff;
      scl_in   = scl_ff;
      sda_in   = sda_ff;
      stage_in = stage_ff;
      nack_in  = nack_ff;
      err_in   = err_ff;
      ev_valid = 1'b0;
      ev_byte  = '0;
      ev_done  = 1'b0;
      do_go    = 1'b0;
      go_ph    = i2cm_pkg::PH_IDLE;

      case (req_data.req_type)
         i2cm_pkg::REQ_BEGIN: begin
            if (phase_ff == i2cm_pkg::PH_IDLE) begin
               rd_in    = req_data.is_read;
               addr_in  = req_data.dev_addr;
               reg_in   = req_data.reg_addr;
               left_in  = req_data.byte_count;
               stage_in = i2cm_pkg::STG_ADDR_W;
               bit_in   = '0;
               shift_in = '0;
               nack_in  = 1'b0;
               err_in   = i2cm_pkg::STATUS_OK;
               do_go    = 1'b1;
               go_ph    = i2cm_pkg::PH_ST1;
            end
         end
         i2cm_pkg::REQ_WDATA: begin
            if (phase_ff == i2cm_pkg::PH_WAIT) begin
               shift_in = req_data.write_byte;
               bit_in   = '0;
               stage_in = i2cm_pkg::STG_DATA;
               do_go    = 1'b1;
               go_ph    = i2cm_pkg::PH_TX1;
            end
         end
         i2cm_pkg::REQ_TICK: begin
            if (phase_ff != i2cm_pkg::PH_IDLE && phase_ff != i2cm_pkg::PH_WAIT) begin
               count_in = cnt_inc;
               if (cnt_inc >= limit || cnt_inc == '0) begin
                  do_go = 1'b1;
                  case (phase_ff)
                     i2cm_pkg::PH_ST1: go_ph = i2cm_pkg::PH_ST2;
                     i2cm_pkg::PH_ST2: go_ph = i2cm_pkg::PH_ST3;
                     i2cm_pkg::PH_ST3: begin
                        shift_in = {addr_ff, stage_ff == i2cm_pkg::STG_ADDR_R};
                        bit_in   = '0;
                        go_ph    = i2cm_pkg::PH_TX1;
                     end
                     i2cm_pkg::PH_TX1: go_ph = i2cm_pkg::PH_TX2;
                     i2cm_pkg::PH_TX2: go_ph = i2cm_pkg::PH_TX3;
                     i2cm_pkg::PH_TX3: begin
                        shift_in = {shift_ff[6:0], 1'b0};
                        if (bit_ff == 3'd7) begin
                           bit_in = '0;
                           go_ph  = i2cm_pkg::PH_AK1;
                        end else begin
                           bit_in = bit_ff + 3'd1;
                           go_ph  = i2cm_pkg::PH_TX1;
                        end
                     end
                     i2cm_pkg::PH_AK1: go_ph = i2cm_pkg::PH_AK2;
                     i2cm_pkg::PH_AK2: begin
                        nack_in = req_data.sda_sample;
                        go_ph   = i2cm_pkg::PH_AK3;
                     end
                     i2cm_pkg::PH_AK3: begin
                        // Acknowledge handling depends on which byte just went out.
                        case (stage_ff)
                           i2cm_pkg::STG_ADDR_W: begin
                              if (nack_ff) begin
                                 err_in = i2cm_pkg::STATUS_ADDR_NACK;
                                 go_ph  = i2cm_pkg::PH_STOP;
                              end else begin
                                 shift_in = reg_ff;
                                 bit_in   = '0;
                                 stage_in = i2cm_pkg::STG_REG;
                                 go_ph    = i2cm_pkg::PH_TX1;
                              end
                           end
                           i2cm_pkg::STG_REG: begin
                              if (rd_ff) begin
                                 stage_in = i2cm_pkg::STG_ADDR_R;
                                 go_ph    = i2cm_pkg::PH_ST1;
                              end else if (left_ff == '0) begin
                                 err_in = i2cm_pkg::STATUS_OK;
                                 go_ph  = i2cm_pkg::PH_STOP;
                              end else begin
                                 go_ph = i2cm_pkg::PH_WAIT;
                              end
                           end
                           i2cm_pkg::STG_DATA: begin
                              if (nack_ff) begin
                                 err_in = i2cm_pkg::STATUS_DATA_NACK;
                                 go_ph  = i2cm_pkg::PH_STOP;
                              end else begin
                                 left_in = left_ff - 8'd1;
                                 if (left_ff == 8'd1) begin
                                    err_in = i2cm_pkg::STATUS_OK;
                                    go_ph  = i2cm_pkg::PH_STOP;
                                 end else begin
                                    go_ph = i2cm_pkg::PH_WAIT;
                                 end
                              end
                           end
                           default: begin
                              bit_in   = '0;
                              shift_in = '0;
                              if (left_ff == '0) begin
                                 err_in = i2cm_pkg::STATUS_OK;
                                 go_ph  = i2cm_pkg::PH_STOP;
                              end else begin
                                 go_ph = i2cm_pkg::PH_RX1;
                              end
                           end
                        endcase
                     end
                     i2cm_pkg::PH_RX1: begin
                        shift_in = {shift_ff[6:0], req_data.sda_sample};
                        go_ph    = i2cm_pkg::PH_RX2;
                     end
                     i2cm_pkg::PH_RX2: begin
                        if (bit_ff == 3'd7) begin
                           bit_in   = '0;
                           ev_valid = 1'b1;
                           ev_byte  = shift_ff;
                           go_ph    = i2cm_pkg::PH_MA1;
                        end else begin
                           bit_in = bit_ff + 3'd1;
                           go_ph  = i2cm_pkg::PH_RX1;
                        end
                     end
                     i2cm_pkg::PH_MA1: go_ph = i2cm_pkg::PH_MA2;
                     i2cm_pkg::PH_MA2: go_ph = i2cm_pkg::PH_MA3;
                     i2cm_pkg::PH_MA3: begin
                        sda_in   = 1'b1;
                        left_in  = left_ff - 8'd1;
                        shift_in = '0;
                        if (left_ff == 8'd1) begin
                           err_in = i2cm_pkg::STATUS_OK;
                           go_ph  = i2cm_pkg::PH_STOP;
                        end else begin
                           go_ph = i2cm_pkg::PH_RX1;
                        end
                     end
                     i2cm_pkg::PH_STOP: begin
                        ev_done = 1'b1;
                        go_ph   = i2cm_pkg::PH_IDLE;
                     end
                     default: do_go = 1'b0;
                  endcase
               end
            end
         end
         default: ;
      endcase

      // Entering a phase resets the step timer and sets its line levels.
      if (do_go) begin
         phase_in = go_ph;
         count_in = '0;
         case (go_ph)
            i2cm_pkg::PH_ST1: begin scl_in = 1'b1; sda_in = 1'b1; end
            i2cm_pkg::PH_ST2: begin scl_in = 1'b1; sda_in = 1'b0; end
            i2cm_pkg::PH_ST3: begin scl_in = 1'b0; sda_in = 1'b0; end
            i2cm_pkg::PH_TX1: begin scl_in = 1'b0; sda_in = shift_in[7]; end
            i2cm_pkg::PH_TX2: scl_in = 1'b1;
            i2cm_pkg::PH_TX3: begin
               scl_in = 1'b0;
               if (bit_in == 3'd7) sda_in = 1'b1;
            end
            i2cm_pkg::PH_AK1: begin scl_in = 1'b0; sda_in = 1'b1; end
            i2cm_pkg::PH_AK2: scl_in = 1'b1;
            i2cm_pkg::PH_AK3: scl_in = 1'b0;
            i2cm_pkg::PH_RX1: scl_in = 1'b1;
            i2cm_pkg::PH_RX2: scl_in = 1'b0;
            i2cm_pkg::PH_MA1: begin scl_in = 1'b0; sda_in = (left_in == 8'd1); end
            i2cm_pkg::PH_MA2: scl_in = 1'b1;
            i2cm_pkg::PH_MA3: scl_in = 1'b0;
            i2cm_pkg::PH_WAIT: scl_in = 1'b0;
            i2cm_pkg::PH_STOP: begin scl_in = 1'b1; sda_in = 1'b0; end
            default: begin scl_in = 1'b1; sda_in = 1'b1; end
         endcase
      end

      rsp_in.scl_drive       = scl_in;
      rsp_in.sda_drive       = sda_in;
      rsp_in.read_byte       = ev_byte;
      rsp_in.read_valid      = ev_valid;
      rsp_in.need_write_byte = (phase_in == i2cm_pkg::PH_WAIT);
      rsp_in.busy_res        = (phase_in != i2cm_pkg::PH_IDLE);
      rsp_in.done_res        = ev_done;
      rsp_in.status          = ev_done ? err_ff : i2cm_pkg::STATUS_OK;
   end

   // Control state and line levels.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= i2cm_pkg::PH_IDLE;
         ticks_ff     <= PHASE_TICKS_WIDTH'(i2cm_pkg::PhaseTicksReset);
         count_ff     <= '0;
         bit_ff       <= '0;
         shift_ff     <= '0;
         left_ff      <= '0;
         addr_ff      <= '0;
         reg_ff       <= '0;
         rd_ff        <= 1'b0;
         scl_ff       <= 1'b1;
         sda_ff       <= 1'b1;
         stage_ff     <= i2cm_pkg::STG_ADDR_W;
         nack_ff      <= 1'b0;
         err_ff       <= i2cm_pkg::STATUS_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         ticks_ff <= ticks_in;
         if (accept) begin
            phase_ff <= phase_in;
            count_ff <= count_in;
            bit_ff   <= bit_in;
            shift_ff <= shift_in;
            left_ff  <= left_in;
            addr_ff  <= addr_in;
            reg_ff   <= reg_in;
            rd_ff    <= rd_in;
            scl_ff   <= scl_in;
            sda_ff   <= sda_in;
            stage_ff <= stage_in;
            nack_ff  <= nack_in;
            err_ff   <= err_in;
         end
         if (accept) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   // Result word register.
   always_ff @(posedge clock) begin
      if (accept) rsp_ff <= rsp_in;
   end

endmodule

>>> src/i2cm_checker.sv
// Port-level checker for the I2C register access master, bound to the top level.
// Depends on i2cm_pkg.
`timescale 1ns / 1ps
module i2cm_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input i2cm_pkg::rsp_word_type rsp_data
);

   // Every accepted word yields a result word in the next cycle.
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("no result word after an accepted request word");

   // A stalled result blocks the request side.
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request accepted while result stalled");

   // A completion word reports the bus idle and released.
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.done_res |->
         !rsp_data.busy_res && rsp_data.scl_drive && rsp_data.sda_drive)
      else $error("completion word with bus not idle");

   // Waiting for write data holds SCL low within a transaction.
   a_wait_low: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.need_write_byte |-> rsp_data.busy_res && !rsp_data.scl_drive)
      else $error("write data wait without SCL low");

   // A stalled result word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed while stalled");

endmodule

bind i2c_master_register_access_top i2cm_checker u_i2cm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

>>> test/i2c_master_register_access_checker.sv
// Checker for the I2C register access master: follows the request, result and register
// channels, predicts every result word and compares it as a whole. Depends on i2cm_pkg.
`timescale 1ns / 1ps
module i2c_master_register_access_checker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  i2cm_pkg::req_word_type req_data,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  i2cm_pkg::rsp_word_type rsp_data,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [15:0]            csr_data,
   output int                     fail_count,
   output int                     pending_words
);
   import i2cm_pkg::*;

   // Shadow of the sequencer state.
   phase_type   cur_phase;
   logic [15:0] tick_limit;
   logic [15:0] step_count;
   logic [2:0]  bit_pos;
   logic [7:0]  shifter;
   logic [7:0]  remaining;
   logic [6:0]  device;
   logic [7:0]  register_index;
   logic        reading;
   logic        scl_out;
   logic        sda_out;
   logic [1:0]  byte_stage;
   logic        nacked;
   logic [1:0]  abort_code;
   logic        got_byte;
   logic [7:0]  got_value;
   logic        finished;
   logic [1:0]  finish_code;

   rsp_word_type expected_words[$];

   assign pending_words = expected_words.size();

   task automatic enter(input phase_type p);
      cur_phase  = p;
      step_count = 16'd0;
      case (p)
         PH_ST1:  begin scl_out = 1'b1; sda_out = 1'b1; end
         PH_ST2:  begin scl_out = 1'b1; sda_out = 1'b0; end
         PH_ST3:  begin scl_out = 1'b0; sda_out = 1'b0; end
         PH_TX1:  begin scl_out = 1'b0; sda_out = shifter[7]; end
         PH_TX2:  scl_out = 1'b1;
         PH_TX3:  begin scl_out = 1'b0; if (bit_pos == 3'd7) sda_out = 1'b1; end
         PH_AK1:  begin scl_out = 1'b0; sda_out = 1'b1; end
         PH_AK2:  scl_out = 1'b1;
         PH_AK3:  scl_out = 1'b0;
         PH_RX1:  scl_out = 1'b1;
         PH_RX2:  scl_out = 1'b0;
         PH_MA1:  begin scl_out = 1'b0; sda_out = (remaining == 8'd1); end
         PH_MA2:  scl_out = 1'b1;
         PH_MA3:  scl_out = 1'b0;
         PH_WAIT: scl_out = 1'b0;
         PH_STOP: begin scl_out = 1'b1; sda_out = 1'b0; end
         default: begin cur_phase = PH_IDLE; scl_out = 1'b1; sda_out = 1'b1; end
      endcase
   endtask

   task automatic abort_to_stop(input logic [1:0] code);
      abort_code = code;
      enter(PH_STOP);
   endtask

   // Decide what follows the acknowledge slot of the byte just sent.
   task automatic follow_ack();
      case (byte_stage)
         STG_ADDR_W: begin
            if (nacked) abort_to_stop(STATUS_ADDR_NACK);
            else begin
               shifter = register_index; bit_pos = 3'd0; byte_stage = STG_REG;
               enter(PH_TX1);
            end
         end
         STG_REG: begin
            if (reading) begin byte_stage = STG_ADDR_R; enter(PH_ST1); end
            else if (remaining == 8'd0) abort_to_stop(STATUS_OK);
            else enter(PH_WAIT);
         end
         STG_DATA: begin
            if (nacked) abort_to_stop(STATUS_DATA_NACK);
            else begin
               remaining = remaining - 8'd1;
               if (remaining == 8'd0) abort_to_stop(STATUS_OK); else enter(PH_WAIT);
            end
         end
         default: begin
            bit_pos = 3'd0; shifter = 8'd0;
            if (remaining == 8'd0) abort_to_stop(STATUS_OK); else enter(PH_RX1);
         end
      endcase
   endtask

   task automatic finish_step(input logic sda_in);
      case (cur_phase)
         PH_ST1: enter(PH_ST2);
         PH_ST2: enter(PH_ST3);
         PH_ST3: begin
            shifter = {device, byte_stage == STG_ADDR_R};
            bit_pos = 3'd0;
            enter(PH_TX1);
         end
         PH_TX1: enter(PH_TX2);
         PH_TX2: enter(PH_TX3);
         PH_TX3: begin
            shifter = shifter << 1;
            if (bit_pos == 3'd7) begin bit_pos = 3'd0; enter(PH_AK1); end
            else begin bit_pos = bit_pos + 3'd1; enter(PH_TX1); end
         end
         PH_AK1: enter(PH_AK2);
         PH_AK2: begin nacked = sda_in; enter(PH_AK3); end
         PH_AK3: follow_ack();
         PH_RX1: begin shifter = {shifter[6:0], sda_in}; enter(PH_RX2); end
         PH_RX2: begin
            if (bit_pos == 3'd7) begin
               bit_pos = 3'd0; got_byte = 1'b1; got_value = shifter;
               enter(PH_MA1);
            end else begin
               bit_pos = bit_pos + 3'd1; enter(PH_RX1);
            end
         end
         PH_MA1: enter(PH_MA2);
         PH_MA2: enter(PH_MA3);
         PH_MA3: begin
            sda_out = 1'b1;
            remaining = remaining - 8'd1;
            shifter = 8'd0;
            if (remaining == 8'd0) abort_to_stop(STATUS_OK); else enter(PH_RX1);
         end
         PH_STOP: begin
            finished = 1'b1; finish_code = abort_code; enter(PH_IDLE);
         end
         default: ;
      endcase
   endtask

   // Advance the shadow state by one request word and queue the word it yields.
   task automatic predict_bus_word(input req_word_type w);
      rsp_word_type r;
      logic [15:0] lim;
      lim = (tick_limit == 16'd0) ? 16'd1 : tick_limit;
      got_byte = 1'b0; got_value = 8'd0; finished = 1'b0; finish_code = 2'd0;
      case (w.req_type)
         REQ_BEGIN: if (cur_phase == PH_IDLE) begin
            reading = w.is_read; device = w.dev_addr; register_index = w.reg_addr;
            remaining = w.byte_count; byte_stage = STG_ADDR_W; bit_pos = 3'd0;
            shifter = 8'd0; nacked = 1'b0; abort_code = STATUS_OK;
            enter(PH_ST1);
         end
         REQ_WDATA: if (cur_phase == PH_WAIT) begin
            shifter = w.write_byte; bit_pos = 3'd0; byte_stage = STG_DATA;
            enter(PH_TX1);
         end
         REQ_TICK: if (cur_phase != PH_IDLE && cur_phase != PH_WAIT) begin
            step_count = step_count + 16'd1;
            if (step_count >= lim || step_count == 16'd0) finish_step(w.sda_sample);
         end
         default: ;
      endcase
      r.scl_drive       = scl_out;
      r.sda_drive       = sda_out;
      r.read_byte       = got_byte ? got_value : 8'd0;
      r.read_valid      = got_byte;
      r.need_write_byte = (cur_phase == PH_WAIT);
      r.busy_res        = (cur_phase != PH_IDLE);
      r.done_res        = finished;
      r.status          = finished ? finish_code : 2'd0;
      expected_words.push_back(r);
   endtask

   // Result words are compared before the request at the same edge is predicted,
   // since the block's result word is registered.
   always @(posedge clock) begin
      rsp_word_type e;
      if (reset) begin
         cur_phase = PH_IDLE; tick_limit = PhaseTicksReset; step_count = 16'd0;
         bit_pos = 3'd0; shifter = 8'd0; remaining = 8'd0; device = 7'd0;
         register_index = 8'd0; reading = 1'b0; scl_out = 1'b1; sda_out = 1'b1;
         byte_stage = STG_ADDR_W; nacked = 1'b0; abort_code = STATUS_OK;
         expected_words.delete();
         fail_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected result word %h", $time, rsp_data);
            end else begin
               e = expected_words.pop_front();
               if (e != rsp_data) begin
                  fail_count++;
                  $display("%0t: result mismatch: expected %p actual %p", $time, e, rsp_data);
               end
            end
         end
         if (csr_valid && csr_ready) tick_limit = csr_data;
         if (req_valid && req_ready) predict_bus_word(req_data);
      end
   end

endmodule

>>> test/tb_i2c_master_register_access_top.sv
// Testbench top for the I2C register access master: clock, reset, request and register
// stimulus, result stalls and the verdict. Depends on i2cm_pkg and the checker module.
`timescale 1ns / 1ps
module tb_i2c_master_register_access_top;
   import i2cm_pkg::*;

   localparam int WatchdogLimit = 20000;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   req_word_type req_data;
   logic         rsp_valid;
   logic         rsp_ready;
   rsp_word_type rsp_data;
   logic         csr_valid;
   logic         csr_ready;
   logic [15:0]  csr_data;
   int           fail_count;
   int           pending_words;
   int           words_sent;
   int           quiet_cycles;
   logic         steady;
   logic         stress_done;

   i2c_master_register_access_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   i2c_master_register_access_checker checker_inst (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data),
      .fail_count(fail_count), .pending_words(pending_words)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Receiver stalls about 18 percent of the time, except during the steady stretch.
   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= steady || ($urandom_range(99) >= 18);
   end

   // Ends the run when nothing moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
         $display("** i2c_master_register_access_top: FAILED **");
         $finish;
      end
   end

   // Valid stays high after an accepted word until the next idle cycle or the next word.
   task automatic send_word(input req_word_type w);
      while (!steady && $urandom_range(99) < 18) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (!req_ready);
      words_sent++;
   endtask

   function automatic req_word_type tick_word(input logic sda);
      req_word_type w;
      w = req_word_type'({$urandom, $urandom});
      w.req_type   = REQ_TICK;
      w.sda_sample = sda;
      return w;
   endfunction

   // Wait for every result, let the block settle, then write the tick setting.
   task automatic set_phase_ticks(input logic [15:0] value);
      req_valid <= 1'b0;
      while (pending_words != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // One complete transaction: begin word, then ticks with acknowledge and read data,
   // supplying write bytes when asked. A few ticks carry a NACK or noise.
   task automatic run_transfer(input logic rd, input logic [7:0] count,
                               input int nack_pct);
      req_word_type w;
      int guard;
      w = req_word_type'({$urandom, $urandom});
      w.req_type = REQ_BEGIN; w.is_read = rd; w.byte_count = count;
      send_word(w);
      guard = 0;
      // Keep going until the transaction is over; a word count bound stops runaways.
      do begin
         while (pending_words != 0 && !steady && $urandom_range(3) == 0) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
         if (dut.rsp_data.need_write_byte === 1'b0 || $urandom_range(9) != 0) begin
            w = tick_word($urandom_range(99) < nack_pct ? 1'b1 : 1'b0);
            if (rd) w.sda_sample = $urandom;
            if ($urandom_range(9) == 0) w.req_type = REQ_WDATA;
         end else begin
            w = req_word_type'({$urandom, $urandom});
            w.req_type = ($urandom_range(15) == 0) ? 2'd3 : REQ_WDATA;
         end
         send_word(w);
         guard++;
      end while (guard < 400 && words_sent < 100000 &&
                 !(rsp_data.busy_res === 1'b0 && guard > 2));
   endtask

   initial begin
      req_word_type w;
      req_valid = 1'b0; req_data = '0; csr_valid = 1'b0; csr_data = '0;
      reset = 1'b1; steady = 1'b0; words_sent = 0;
      stress_done = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part with the smallest setting: extremes and odd codes.
      set_phase_ticks(16'd0);
      w = '1; w.req_type = REQ_WDATA; send_word(w);
      w = '1; w.req_type = 2'd3;      send_word(w);
      w = '0; send_word(w);
      w = '1; w.req_type = REQ_BEGIN; w.is_read = 1'b0; w.byte_count = 8'd1; send_word(w);
      w = '1; w.req_type = REQ_BEGIN; send_word(w);
      repeat (12) send_word(tick_word(1'b1));
      w = '0; w.req_type = REQ_BEGIN; send_word(w);
      repeat (8) send_word(tick_word(1'b0));

      set_phase_ticks(16'd1);
      run_transfer(1'b0, 8'd0, 0);
      run_transfer(1'b1, 8'd0, 0);
      run_transfer(1'b1, 8'd2, 0);
      run_transfer(1'b0, 8'd2, 0);
      run_transfer(1'b0, 8'd3, 60);

      // Random part: mostly clean transfers of few bytes, some NACKs and noise.
      while (words_sent < 1450) begin
         if (words_sent > 700 && !stress_done) begin
            set_phase_ticks(16'd2);
            stress_done = 1'b1;
         end
         if (words_sent > 900 && words_sent < 1100) steady = 1'b1;
         else steady = 1'b0;
         run_transfer($urandom, ($urandom_range(19) == 0) ? 8'($urandom) % 8'd6
                                                           : 8'($urandom_range(3)),
                      ($urandom_range(4) == 0) ? 30 : 2);
      end

      // Largest setting: one begin and a handful of ticks, then setting one with more ticks, then back to reset value.
      set_phase_ticks(16'hFFFF);
      w = '0; w.req_type = REQ_BEGIN; send_word(w);
      repeat (20) send_word(tick_word(1'b0));
      set_phase_ticks(16'd1);
      repeat (60) send_word(tick_word(1'b0));
      set_phase_ticks(PhaseTicksReset);

      while (pending_words != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (fail_count == 0) $display("** i2c_master_register_access_top: PASSED **");
      else $display("** i2c_master_register_access_top: FAILED **");
      $finish;
   end

endmodule
